// File: hdl/xrru_pkg.sv
package xrru_pkg;

  localparam int unsigned WORD_W = 32;

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  localparam logic [WORD_W-1:0] PERCENT_SPAN  = 32'd100;
  localparam logic [WORD_W-1:0] PERCENT_MOD   = 32'd101;
  localparam logic [WORD_W-1:0] PERMILLE_SPAN = 32'd1000;

  typedef enum logic [2:0] {
    FUNC_RAW      = 3'd0,
    FUNC_UPTO     = 3'd1,
    FUNC_INDEX    = 3'd2,
    FUNC_RANGE    = 3'd3,
    FUNC_SYM      = 3'd4,
    FUNC_COIN     = 3'd5,
    FUNC_PERCENT  = 3'd6,
    FUNC_PERMILLE = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
  } rsp_t;

  function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    t = x ^ (x << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return t;
  endfunction

endpackage

// File: hdl/xorshift_ranged_random_unit_core.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_t  (func, arg_a, arg_b)
// rsp       out        rsp_valid/rsp_stall   rsp_t  (value, flag)
// cfg       in         cfg_valid/cfg_ready   seed   (32 bit)
//
// A request goes from transfer through ST_ORDER, ST_LOAD, ST_DIVIDE (32 remainder steps,
// then the remainder is handed over) and ST_FINISH to rsp_valid; ST_DIVIDE only when a remainder is needed.
// One request is worked on at a time; req_stall is high from transfer to finish.
// A finished result waits in the output register while the next request runs.
// Synchronous reset loads the generator with one; cfg is taken only when idle.
module xorshift_ranged_random_unit_core import xrru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed
);

  state_t            state;
  state_t            state_next;
  func_t             func;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] num;
  logic              skip;
  logic [WORD_W-1:0] generator;
  logic [WORD_W-1:0] draw_value;
  logic [WORD_W-1:0] width;
  logic [WORD_W-1:0] divisor;
  logic [WORD_W-1:0] rem_value;
  logic              rem_done;
  logic              need_draw;
  logic              need_div;
  logic              hi_pos;
  logic              take_req;
  logic              seed_wr;
  logic              out_free;
  logic              draw_en;
  logic              div_start;
  logic              out_load;
  rsp_t              rsp_next;

  assign take_req   = req_valid && !req_stall;
  assign seed_wr    = cfg_valid && cfg_ready;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign draw_value = xorshift_next(generator);

  always_comb begin
    width     = hi - lo + 32'd1;
    hi_pos    = $signed(hi) > 32'sd0;
    need_draw = 1'b1;
    need_div  = 1'b0;
    divisor   = width;
    case (func) inside
      FUNC_RAW, FUNC_COIN: begin
        need_draw = 1'b1;
      end
      FUNC_UPTO: begin
        need_draw = hi_pos;
        need_div  = 1'b1;
        divisor   = hi + 32'd1;
      end
      FUNC_INDEX: begin
        need_draw = hi > 32'd1;
        need_div  = 1'b1;
        divisor   = hi;
      end
      FUNC_RANGE, FUNC_SYM: begin
        need_div = width != '0;
        divisor  = width;
      end
      FUNC_PERCENT: begin
        need_draw = hi_pos && ($signed(hi) < $signed(PERCENT_SPAN));
        need_div  = 1'b1;
        divisor   = PERCENT_MOD;
      end
      FUNC_PERMILLE: begin
        need_draw = hi_pos && ($signed(hi) < $signed(PERMILLE_SPAN));
        need_div  = 1'b1;
        divisor   = PERMILLE_SPAN;
      end
      default: begin
        need_draw = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (take_req) state_next = ST_ORDER;
      ST_ORDER:  state_next = ST_LOAD;
      ST_LOAD:   state_next = (need_draw && need_div) ? ST_DIVIDE : ST_FINISH;
      ST_DIVIDE: if (rem_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    cfg_ready = 1'b0;
    draw_en   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_LOAD: begin
        draw_en   = need_draw;
        div_start = need_draw && need_div;
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    rsp_next.value = '0;
    rsp_next.flag  = 1'b0;
    case (func) inside
      FUNC_RAW:             rsp_next.value = num;
      FUNC_UPTO, FUNC_INDEX: rsp_next.value = skip ? '0 : num;
      FUNC_RANGE, FUNC_SYM: rsp_next.value = num + lo;
      FUNC_COIN:            rsp_next.flag  = num[0];
      FUNC_PERCENT:
        rsp_next.flag = skip ? ($signed(hi) >= $signed(PERCENT_SPAN)) : (num <= hi);
      FUNC_PERMILLE:
        rsp_next.flag = skip ? ($signed(hi) >= $signed(PERMILLE_SPAN)) : (num < hi);
      default:              rsp_next.value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      generator <= 32'd1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_wr) begin
        generator <= (seed == '0) ? 32'd1 : seed;
      end else if (draw_en) begin
        generator <= draw_value;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_req) begin
      func <= req.func;
      hi   <= req.arg_b;
      lo   <= (req.func == FUNC_SYM) ? 32'd0 - req.arg_b : req.arg_a;
    end
    if (state == ST_ORDER) begin
      if (func == FUNC_RANGE || func == FUNC_SYM) begin
        if ($signed(hi) < $signed(lo)) begin
          lo <= hi;
          hi <= lo;
        end
      end else begin
        lo <= '0;
      end
    end
    if (state == ST_LOAD) begin
      skip <= !need_draw;
      num  <= draw_value;
    end
    if (rem_done) begin
      num <= rem_value;
    end
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  xrru_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (draw_value),
    .divisor   (divisor),
    .done      (rem_done),
    .remainder (rem_value)
  );

`ifndef SYNTHESIS
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    generator != '0)
    else $error("generator reached zero");

  a_rem_in_divide: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_DIVIDE)
    else $error("remainder finished outside divide state");

  a_gen_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD && !seed_wr) |=> $stable(generator))
    else $error("generator moved without a draw or seed transfer");
`endif

endmodule

// File: hdl/xrru_rem.sv
module xrru_rem import xrru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] remainder
);

  logic              busy;
  logic [4:0]        cnt;
  logic [WORD_W-1:0] shreg;
  logic [WORD_W-1:0] div;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_next;

  // restoring step: one quotient bit per cycle while busy
  always_comb begin
    trial    = {remainder, shreg[WORD_W-1]};
    diff     = trial - {1'b0, div};
    rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt       <= 5'd31;
      remainder <= '0;
      shreg     <= dividend;
      div       <= divisor;
    end else if (busy) begin
      cnt       <= cnt - 5'd1;
      remainder <= rem_next;
      shreg     <= shreg << 1;
    end
  end

endmodule

// File: test/tb.sv
module tb import xrru_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 310;

  typedef struct {
    req_t        r;
    bit          typed;
    rsp_t        want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] seed = 32'd0;

  logic [31:0] rng_state = 32'd1;
  rsp_t        answers_due[$];
  dir_row_t    directed_rows[$];
  rsp_t        head_rsp;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  xorshift_ranged_random_unit_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_fail(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (answers_due.size() == 0) begin
        report_fail($sformatf("unexpected result value=%h flag=%b", rsp.value, rsp.flag));
      end else begin
        head_rsp = answers_due.pop_front();
        if (rsp.value !== head_rsp.value)
          report_fail($sformatf("value got %h want %h", rsp.value, head_rsp.value));
        if (rsp.flag !== head_rsp.flag)
          report_fail($sformatf("flag got %b want %b", rsp.flag, head_rsp.flag));
      end
    end
  end

  function automatic logic [31:0] advance_rng();
    logic [31:0] x;
    x = rng_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_state = x;
    return x;
  endfunction

  function automatic logic [31:0] draw_between(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] t;
    logic [31:0] width;
    logic [31:0] d;
    if ($signed(hi) < $signed(lo)) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    width = hi - lo + 32'd1;
    d = advance_rng();
    if (width != 32'd0)
      d = d % width;
    return d + lo;
  endfunction

  function automatic rsp_t predict_answer(input req_t r);
    logic [31:0]        a;
    logic [31:0]        b;
    logic signed [31:0] bs;
    logic [31:0]        d;
    rsp_t               res;
    a   = r.arg_a;
    b   = r.arg_b;
    bs  = r.arg_b;
    res = '0;
    case (r.func)
      FUNC_RAW: res.value = advance_rng();
      FUNC_UPTO: begin
        if (bs > 0)
          res.value = advance_rng() % (b + 32'd1);
      end
      FUNC_INDEX: begin
        if (b > 32'd1)
          res.value = advance_rng() % b;
      end
      FUNC_RANGE: res.value = draw_between(a, b);
      FUNC_SYM: res.value = draw_between(32'd0 - b, b);
      FUNC_COIN: begin
        d        = advance_rng();
        res.flag = d[0];
      end
      FUNC_PERCENT: begin
        if (bs >= $signed(PERCENT_SPAN))
          res.flag = 1'b1;
        else if (bs > 0)
          res.flag = ((advance_rng() % PERCENT_MOD) <= b);
      end
      default: begin
        if (bs >= $signed(PERMILLE_SPAN))
          res.flag = 1'b1;
        else if (bs > 0)
          res.flag = ((advance_rng() % PERMILLE_SPAN) + 32'd1 <= b);
      end
    endcase
    return res;
  endfunction

  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = predict_answer(r);
    answers_due.push_back(typed ? want : p);
  endtask

  task automatic write_seed(input logic [31:0] s);
    req_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    seed      <= s;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rng_state = (s != 32'd0) ? s : 32'd1;
  endtask

  task automatic add_row(input func_t f, input logic [31:0] a, input logic [31:0] b,
                         input bit typed, input logic [31:0] v, input logic fl);
    dir_row_t row;
    row.r.func     = f;
    row.r.arg_a    = a;
    row.r.arg_b    = b;
    row.typed      = typed;
    row.want.value = v;
    row.want.flag  = fl;
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return 32'd0 + $urandom_range(1300) - 32'd200;
      3:       return 32'd0 + $urandom_range(40) - 32'd20;
      4: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return PERCENT_SPAN;
          4:       return PERMILLE_SPAN;
          default: return 32'd1;
        endcase
      end
      default: return 32'h7fff_ffff - $urandom_range(15);
    endcase
  endfunction

  initial begin
    req_t r;
    rsp_t none;
    logic [31:0] phase_seed [5];
    int idle_set  [5];
    int stall_set [5];
    none = '0;
    phase_seed = '{32'd0, 32'hffff_ffff, 32'd0, 32'h8000_0000, 32'd1};
    phase_seed[2] = $urandom;
    idle_set  = '{0, 61, 0, 24, 0};
    stall_set = '{0, 0, 61, 24, 0};

    // directed: generator fresh from reset, no idling
    add_row(FUNC_RAW,      32'd0,          32'd0,          1, 32'h0004_2021, 1'b0);
    add_row(FUNC_UPTO,     32'd0,          32'd0,          1, 32'd0,         1'b0);
    add_row(FUNC_UPTO,     32'd0,          32'h8000_0000,  1, 32'd0,         1'b0);
    add_row(FUNC_UPTO,     32'hffff_ffff,  32'h7fff_ffff,  0, 32'd0,         1'b0);
    add_row(FUNC_UPTO,     32'd0,          32'd1,          0, 32'd0,         1'b0);
    add_row(FUNC_INDEX,    32'd0,          32'd1,          1, 32'd0,         1'b0);
    add_row(FUNC_INDEX,    32'd0,          32'd0,          1, 32'd0,         1'b0);
    add_row(FUNC_INDEX,    32'd0,          32'hffff_ffff,  0, 32'd0,         1'b0);
    add_row(FUNC_INDEX,    32'd0,          32'd2,          0, 32'd0,         1'b0);
    add_row(FUNC_RANGE,    -32'sd10,       32'd10,         0, 32'd0,         1'b0);
    add_row(FUNC_RANGE,    32'd10,         -32'sd10,       0, 32'd0,         1'b0);
    add_row(FUNC_RANGE,    32'h8000_0000,  32'h7fff_ffff,  0, 32'd0,         1'b0);
    add_row(FUNC_RANGE,    32'd5,          32'd5,          1, 32'd5,         1'b0);
    add_row(FUNC_SYM,      32'd0,          32'h8000_0000,  1, 32'h8000_0000, 1'b0);
    add_row(FUNC_SYM,      32'd0,          32'h7fff_ffff,  0, 32'd0,         1'b0);
    add_row(FUNC_SYM,      32'hffff_ffff,  32'd0,          1, 32'd0,         1'b0);
    add_row(FUNC_COIN,     32'hffff_ffff,  32'hffff_ffff,  0, 32'd0,         1'b0);
    add_row(FUNC_PERCENT,  32'd0,          32'd0,          1, 32'd0,         1'b0);
    add_row(FUNC_PERCENT,  32'd0,          32'd100,        1, 32'd0,         1'b1);
    add_row(FUNC_PERCENT,  32'd0,          32'h8000_0000,  1, 32'd0,         1'b0);
    add_row(FUNC_PERCENT,  32'd0,          32'd50,         0, 32'd0,         1'b0);
    add_row(FUNC_PERMILLE, 32'd0,          32'd1000,       1, 32'd0,         1'b1);
    add_row(FUNC_PERMILLE, 32'd0,          32'hffff_ffff,  1, 32'd0,         1'b0);
    add_row(FUNC_PERMILLE, 32'd0,          32'd999,        0, 32'd0,         1'b0);
    add_row(FUNC_PERMILLE, 32'd0,          32'd1,          0, 32'd0,         1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_req(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      write_seed(phase_seed[ph]);
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r.func  = func_t'($urandom_range(7));
        r.arg_a = pick_arg();
        r.arg_b = pick_arg();
        send_req(r, 1'b0, none);
      end
    end

    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answers_due.size() != 0)
      report_fail("results still outstanding at end");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
